>>> src/fsf_pkg.sv
// Shared types and constants of the FIR smoothing filter.
`default_nettype none

package fsf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int NCOEF      = 8;
    localparam int COEF_IDX_W = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + COEF_IDX_W + 1;
    localparam int FRAC_BITS  = 14;

    localparam logic signed [COEF_W-1:0] COEF0_RESET = 16'sd16384;

    // Rounding offsets: half for positive sums, one less for negative sums
    // so that the arithmetic shift rounds halves away from zero.
    localparam logic signed [ACC_W-1:0] RND_POS = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] RND_NEG = ACC_W'((1 << (FRAC_BITS - 1)) - 1);

    localparam logic signed [ACC_W-1:0] ACC_SAT_MAX =
        {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_SAT_MIN =
        {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic load;      // take input word, clear accumulator
        logic mul;       // register one product
        logic acc;       // add registered product into accumulator
        logic shift;     // advance the delay line
        logic out_load;  // load rounded result into output register
    } fsf_cmd_t;

endpackage

`default_nettype wire

>>> src/fir_smoothing_filter_top.sv
// Top level of the direct-form FIR smoothing filter.
// Input channel: in_valid / in_stall with sample_in (signed 16 bits). A word is
// taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with sample_out (signed 16 bits); one
// filtered word for every input word, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; indexes 0..7
// write coef_0..coef_7 (signed Q2.14), higher indexes are ignored. cfg_ready is
// always high; write only while the filter is idle.
// Schedule: one shared multiplier serves the taps one per cycle, so a word
// passes through these steps: a step to take it, TAPS multiplies, a final
// accumulate and delay-line advance, and a step to round and load the output register.
// out_valid rises as the output register is loaded; the next word can
// be taken on the edge after that.
// The output register parts the two sides: a new word is accepted while a
// result still waits. If the receiver stalls, the next result is held inside
// and in_stall stays high until the output register frees up.
// Reset clears the delay line to zero, sets coef_0 to 1.0 and the other
// coefficients to zero, and empties the output register.
`default_nettype none

module fir_smoothing_filter_top
    import fsf_pkg::*;
#(
    parameter int TAPS = 8
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [SAMPLE_W-1:0]  sample_in,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [SAMPLE_W-1:0]       sample_out,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [COEF_W-1:0]           cfg_data
);

    localparam int CNT_W = $clog2(TAPS);

    fsf_cmd_t         cmd;
    logic [CNT_W-1:0] tap_idx;

    assign cfg_ready = 1'b1;

    fsf_ctrl #(
        .TAPS  (TAPS),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .tap_idx   (tap_idx)
    );

    fsf_datapath #(
        .TAPS  (TAPS),
        .CNT_W (CNT_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .tap_idx    (tap_idx),
        .sample_in  (sample_in),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_out (sample_out)
    );

    // an accepted word runs through all taps before the delay line advances
    a_load_to_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> ##(TAPS + 1) cmd.shift)
        else $error("delay line did not advance after all taps");

    // never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("output register overwritten while stalled");

    // no new word while one is in progress
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a word is in progress");

endmodule

`default_nettype wire

>>> src/fsf_datapath.sv
// Datapath: coefficient registers, delay line, shared multiplier, accumulator, rounding.
`default_nettype none

module fsf_datapath
    import fsf_pkg::*;
#(
    parameter int TAPS  = 8,
    parameter int CNT_W = 3
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fsf_cmd_t                    cmd,
    input  wire logic [CNT_W-1:0]            tap_idx,
    input  wire logic signed [SAMPLE_W-1:0]  sample_in,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [COEF_W-1:0]           cfg_data,
    output logic signed [SAMPLE_W-1:0]       sample_out
);

    logic signed [COEF_W-1:0]   coef_reg [NCOEF];
    // Entry 0 holds the current word, entry k the word k steps old.
    logic signed [SAMPLE_W-1:0] taps_reg [TAPS];
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    logic signed [ACC_W-1:0]    rnd;
    logic signed [ACC_W-1:0]    quo;
    logic signed [SAMPLE_W-1:0] sat_next;
    logic [COEF_IDX_W-1:0]      coef_idx;

    assign coef_idx = COEF_IDX_W'(tap_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_reg[i] <= (i == 0) ? COEF0_RESET : '0;
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NCOEF)))
        begin
            coef_reg[cfg_index[COEF_IDX_W-1:0]] <= $signed(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            taps_reg[0] <= sample_in;
        end
        else if (cmd.shift)
        begin
            for (int i = 1; i < TAPS; i++)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(coef_reg[coef_idx]) * PROD_W'(taps_reg[tap_idx]);
        end
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.out_load)
        begin
            sample_out_reg <= sat_next;
        end
    end

    always_comb
    begin
        rnd = acc_reg + (acc_reg[ACC_W-1] ? RND_NEG : RND_POS);
        quo = rnd >>> FRAC_BITS;
        if (quo > ACC_SAT_MAX)
        begin
            sat_next = ACC_SAT_MAX[SAMPLE_W-1:0];
        end
        else if (quo < ACC_SAT_MIN)
        begin
            sat_next = ACC_SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            sat_next = quo[SAMPLE_W-1:0];
        end
    end

    assign sample_out = sample_out_reg;

endmodule

`default_nettype wire

>>> src/fsf_ctrl.sv
// Controller: sequences one multiply per tap, rounding and output handoff.
`default_nettype none

module fsf_ctrl
    import fsf_pkg::*;
#(
    parameter int TAPS  = 8,
    parameter int CNT_W = 3
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output fsf_cmd_t              cmd,
    output logic [CNT_W-1:0]      tap_idx
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_LAST,
        ST_RES
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mul  = 1'b1;
                cmd.acc  = (cnt_reg != '0);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TAPS - 1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                cmd.acc    = 1'b1;
                cmd.shift  = 1'b1;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                // hold the result until the output register is free
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign tap_idx   = cnt_reg;

endmodule

`default_nettype wire

>>> tb/sv/fir_smoothing_filter_checker.sv
// Checker for the FIR smoothing filter: tracks coefficients and history, predicts and compares.
module fir_smoothing_filter_checker
    import fsf_pkg::*;
#(
    parameter int TAPS = 8
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample_out,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [COEF_W-1:0]          cfg_data,
    output int                              mismatches,
    output int                              pending
);

    localparam longint HALF_LSB    = longint'(1) << (FRAC_BITS - 1);
    localparam longint OUT_POS_MAX = 32767;
    localparam longint OUT_NEG_MAG = 32768;
    localparam int     REPORT_MAX  = 10;

    logic signed [COEF_W-1:0]   coef_q [NCOEF];
    logic signed [SAMPLE_W-1:0] history [TAPS-1];
    logic signed [SAMPLE_W-1:0] filtered_q [$];

    // Weighted sum over the new word and its history, then advance the history.
    function automatic logic signed [SAMPLE_W-1:0] filter_word(
        input logic signed [SAMPLE_W-1:0] x);
        longint acc;
        longint mag;
        longint rounded;
        acc = longint'(coef_q[0]) * longint'(x);
        for (int k = 1; k < TAPS; k++)
        begin
            acc += longint'(coef_q[k]) * longint'(history[k-1]);
        end
        for (int k = TAPS - 2; k > 0; k--)
        begin
            history[k] = history[k-1];
        end
        history[0] = x;
        mag = (acc < 0) ? -acc : acc;
        rounded = (mag + HALF_LSB) >>> FRAC_BITS;
        if (acc < 0)
        begin
            return (rounded > OUT_NEG_MAG) ? SAMPLE_W'(-OUT_NEG_MAG) : SAMPLE_W'(-rounded);
        end
        return (rounded > OUT_POS_MAX) ? SAMPLE_W'(OUT_POS_MAX) : SAMPLE_W'(rounded);
    endfunction

    task automatic flag(input string msg);
        if (mismatches < REPORT_MAX)
        begin
            $display("%0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NCOEF; k++)
            begin
                coef_q[k] = '0;
            end
            coef_q[0] = COEF0_RESET;
            for (int k = 0; k < TAPS - 1; k++)
            begin
                history[k] = '0;
            end
            filtered_q.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            // indexes past the last coefficient are dropped by the block
            if (cfg_valid && cfg_ready && cfg_index < NCOEF)
            begin
                coef_q[cfg_index[COEF_IDX_W-1:0]] = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                filtered_q.push_back(filter_word(sample_in));
            end
            if (out_valid && !out_stall)
            begin
                if (filtered_q.size() == 0)
                begin
                    flag($sformatf("unexpected sample_out word %0d", sample_out));
                end
                else
                begin
                    logic signed [SAMPLE_W-1:0] want;
                    want = filtered_q.pop_front();
                    if (sample_out !== want)
                    begin
                        flag($sformatf("sample_out mismatch: expected %0d, got %0d",
                            want, sample_out));
                    end
                end
            end
            pending = filtered_q.size();
        end
    end

endmodule

>>> tb/sv/fir_smoothing_filter_top_tb.sv
// Testbench top for the FIR smoothing filter: stimulus, coefficient phases, verdict.
module fir_smoothing_filter_top_tb;
    import fsf_pkg::*;

    localparam int TAPS          = 8;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int LONG_HOLD     = 300;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 133;
    localparam int COEF_IDX_0    = 0;
    localparam int CFG_IDX_LAST  = (1 << CFG_IDX_W) - 1;

    localparam logic signed [COEF_W-1:0]   COEF_MAX   = 16'sh7FFF;
    localparam logic signed [COEF_W-1:0]   COEF_MIN   = 16'sh8000;
    localparam logic signed [COEF_W-1:0]   Q14_HALF   = 16'sd8192;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum int
    {
        COEF_RANDOM,
        COEF_LOWPASS,
        COEF_ALL_MAX,
        COEF_ALL_MIN,
        COEF_ALTERNATE,
        COEF_SMALL,
        COEF_HALF
    } coef_mode_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [COEF_W-1:0]          cfg_data;

    int mismatches;
    int pending;
    int idle_cycles;
    bit sender_eager;

    always #2 clk = ~clk;

    fir_smoothing_filter_top #(
        .TAPS(TAPS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_in(sample_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_out(sample_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    fir_smoothing_filter_checker #(
        .TAPS(TAPS)
    ) checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_in(sample_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_out(sample_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .pending(pending)
    );

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_W'($urandom_range(0, 1024) - 512);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(input coef_mode_t mode, input int k);
        case (mode)
            COEF_LOWPASS:   return COEF_W'($urandom_range(0, 4096));
            COEF_ALL_MAX:   return COEF_MAX;
            COEF_ALL_MIN:   return COEF_MIN;
            COEF_ALTERNATE: return (k % 2 == 0) ? COEF_MAX : COEF_MIN;
            COEF_SMALL:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    return '0;
                end
                return COEF_W'($urandom_range(0, 1024) - 512);
            end
            COEF_HALF:      return (k == COEF_IDX_0) ? Q14_HALF : '0;
            default:        return COEF_W'($urandom());
        endcase
    endfunction

    // Keep cfg_valid high across back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_coefs(input coef_mode_t mode);
        for (int k = 0; k < NCOEF; k++)
        begin
            write_reg(CFG_IDX_W'(COEF_IDX_0 + k), pick_coef(mode, k));
        end
        // out-of-range index: must leave every coefficient alone
        write_reg(CFG_IDX_W'($urandom_range(NCOEF, CFG_IDX_LAST)), COEF_W'($urandom()));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 18);
        repeat (gap) @(negedge clk) in_valid <= 1'b0;
        @(negedge clk);
        in_valid  <= 1'b1;
        sample_in <= x;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Wait until every filtered word is back, then let the pipeline settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (TAPS + 4) @(negedge clk);
    endtask

    initial
    begin : receiver
        int stall_left;
        int hold_left;
        int words_taken;
        bit eager;
        stall_left  = 0;
        hold_left   = 0;
        words_taken = 0;
        eager       = 1'b0;
        out_stall   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                words_taken++;
                if (words_taken % 80 == 0)
                begin
                    eager = !eager;
                end
                // hold off long enough for the filter to back up into its input
                if (words_taken == 150 || words_taken == 900)
                begin
                    hold_left = LONG_HOLD;
                end
                stall_left = eager ? 0 : $urandom_range(0, 18);
            end
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("fir_smoothing_filter_top test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        sample_in    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sender_eager = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset coefficients pass the word through unchanged
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        drain();

        // half weight: halves round away from zero
        load_coefs(COEF_HALF);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd3);
        send_sample(-16'sd3);
        drain();

        // full-scale weights drive the sum into both saturation limits
        load_coefs(COEF_ALL_MAX);
        repeat (4) send_sample(SAMPLE_MAX);
        repeat (4) send_sample(SAMPLE_MIN);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            load_coefs(coef_mode_t'(phase % 6));
            sender_eager = (phase % 3 == 1);
            repeat (PHASE_WORDS) send_sample(pick_sample());
            drain();
        end

        if (mismatches == 0)
        begin
            $display("fir_smoothing_filter_top test passed");
        end
        else
        begin
            $display("fir_smoothing_filter_top test failed");
        end
        $finish;
    end

endmodule
